FILE: rtl/core/tpc_pkg.sv
// Shared types, codes and fixed-point helpers for the two-port parameter converter.
// No dependencies; imported by tpc_xform, two_port_param_convert_top and tb_top.
`timescale 1ns / 1ps
package tpc_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * WORD_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int NUM_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int SHN_W  = MAG_W + FRAC_W;
  localparam int QUO_W  = WORD_W;
  localparam int CMP_W  = MAG_W + QUO_W;
  localparam int MAT_W  = 8 * WORD_W;
  localparam int RZ_W   = WORD_W - 1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [NUM_W-1:0]  num_t;

  typedef struct packed {
    word_t re;
    word_t im;
  } cplx_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } wsat_t;

  typedef struct packed {
    cplx_t val;
    logic  sat;
  } csat_t;

  typedef struct packed {
    logic valid;
    logic bad;
    logic sat;
  } xf_flags_t;

  typedef enum logic [2:0] {
    XF_PASS,
    XF_INV,
    XF_S2Z,
    XF_ABCD,
    XF_Z2S,
    XF_BAD
  } xf_mode_t;

  localparam logic [1:0] SRC_Z = 2'd0;
  localparam logic [1:0] SRC_Y = 2'd1;
  localparam logic [1:0] SRC_S = 2'd2;

  localparam logic [1:0] TGT_Z    = 2'd0;
  localparam logic [1:0] TGT_Y    = 2'd1;
  localparam logic [1:0] TGT_ABCD = 2'd2;
  localparam logic [1:0] TGT_S    = 2'd3;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;
  localparam logic [1:0] REG_REFZ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [RZ_W-1:0] RZ_RESET = RZ_W'(3276800);

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
  localparam word_t WORD_MIN = ~WORD_MAX;
  localparam word_t ONE_W    = word_t'(1) << FRAC_W;
  localparam word_t MONE_W   = -ONE_W;
  localparam cplx_t ONE_C    = '{re: ONE_W, im: '0};
  localparam cplx_t MONE_C   = '{re: MONE_W, im: '0};
  localparam cplx_t ZERO_C   = '{re: '0, im: '0};

  localparam logic [ACC_W-1:0] WORD_TOP = ACC_W'(1) << (WORD_W - 1);
  localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_W - 1);

  // Saturate a sign and magnitude into one word.
  function automatic wsat_t from_mag(input logic neg, input logic [ACC_W-1:0] m);
    logic [ACC_W-1:0] lim;
    logic [ACC_W-1:0] mu;
    wsat_t r;
    lim   = neg ? WORD_TOP : WORD_TOP - ACC_W'(1);
    r.sat = m > lim;
    mu    = r.sat ? lim : m;
    r.val = neg ? word_t'(-mu[WORD_W-1:0]) : word_t'(mu[WORD_W-1:0]);
    return r;
  endfunction

  // Round to nearest, ties away from zero, drop the fraction bits, saturate.
  function automatic wsat_t round_word(input acc_t v);
    logic neg;
    logic [ACC_W-1:0] mag;
    neg = v[ACC_W-1];
    mag = neg ? ACC_W'(-v) : ACC_W'(v);
    return from_mag(neg, (mag + HALF_LSB) >> FRAC_W);
  endfunction

  function automatic wsat_t add_sat(input word_t a, input word_t b, input logic sub);
    logic [WORD_W:0] s;
    wsat_t r;
    s     = sub ? {a[WORD_W-1], a} - {b[WORD_W-1], b} : {a[WORD_W-1], a} + {b[WORD_W-1], b};
    r.sat = s[WORD_W] != s[WORD_W-1];
    r.val = r.sat ? (s[WORD_W] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_W-1:0]);
    return r;
  endfunction

  function automatic csat_t csum(input cplx_t x, input cplx_t y, input logic sub);
    wsat_t r;
    wsat_t i;
    csat_t o;
    r        = add_sat(x.re, y.re, sub);
    i        = add_sat(x.im, y.im, sub);
    o.val.re = r.val;
    o.val.im = i.val;
    o.sat    = r.sat | i.sat;
    return o;
  endfunction

  function automatic prod_t smul(input word_t a, input word_t b);
    return a * b;
  endfunction

endpackage

FILE: rtl/core/tpc_xform.sv
// One conversion pass: complex determinant and numerators, pipelined complex
// division with one quotient bit per stage, then optional reference scaling and doubling.
// Depends on tpc_pkg.
`timescale 1ns / 1ps
module tpc_xform (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  tpc_pkg::xf_mode_t       mode,
  input  tpc_pkg::word_t          rz,
  input  tpc_pkg::xf_flags_t      in_flags,
  input  tpc_pkg::cplx_t [3:0]    in_mat,
  output tpc_pkg::xf_flags_t      out_flags,
  output tpc_pkg::cplx_t [3:0]    out_mat
);
  import tpc_pkg::*;

  localparam int ITER = QUO_W;

  typedef struct packed {
    cplx_t p;
    cplx_t q;
    cplx_t r;
    cplx_t s;
    logic  sub;
  } mac_t;

  function automatic mac_t mk1(input cplx_t p, input cplx_t q);
    mac_t m;
    m.p = p; m.q = q; m.r = ZERO_C; m.s = ZERO_C; m.sub = 1'b0;
    return m;
  endfunction

  function automatic mac_t mk2(input cplx_t p, input cplx_t q, input cplx_t r,
                               input cplx_t s, input logic sub);
    mac_t m;
    m.p = p; m.q = q; m.r = r; m.s = s; m.sub = sub;
    return m;
  endfunction

  // ---------------- operand setup ----------------
  cplx_t rz_c;
  cplx_t base;
  csat_t pl0, pl3, mi0, mi3;
  mac_t  ops [5];
  logic  pre_sat, mode_bad;

  always_comb begin
    rz_c    = '{re: rz, im: '0};
    base    = (mode == XF_S2Z) ? ONE_C : rz_c;
    pl0     = csum(in_mat[0], base, 1'b0);
    pl3     = csum(in_mat[3], base, 1'b0);
    mi0     = (mode == XF_S2Z) ? csum(base, in_mat[0], 1'b1) : csum(in_mat[0], base, 1'b1);
    mi3     = (mode == XF_S2Z) ? csum(base, in_mat[3], 1'b1) : csum(in_mat[3], base, 1'b1);
    pre_sat = 1'b0;
    mode_bad = 1'b0;
    for (int k = 0; k < 5; k++) ops[k] = mk1(ONE_C, ONE_C);
    unique case (mode)
      XF_PASS: begin
        for (int j = 0; j < 4; j++) ops[j+1] = mk1(in_mat[j], ONE_C);
      end
      XF_INV: begin
        ops[0] = mk2(in_mat[0], in_mat[3], in_mat[1], in_mat[2], 1'b1);
        ops[1] = mk1(in_mat[3], ONE_C);
        ops[2] = mk1(in_mat[1], MONE_C);
        ops[3] = mk1(in_mat[2], MONE_C);
        ops[4] = mk1(in_mat[0], ONE_C);
      end
      XF_S2Z: begin
        ops[0]  = mk2(mi0.val, mi3.val, in_mat[1], in_mat[2], 1'b1);
        ops[1]  = mk2(pl0.val, mi3.val, in_mat[1], in_mat[2], 1'b0);
        ops[2]  = mk1(in_mat[1], ONE_C);
        ops[3]  = mk1(in_mat[2], ONE_C);
        ops[4]  = mk2(mi0.val, pl3.val, in_mat[1], in_mat[2], 1'b0);
        pre_sat = pl0.sat | pl3.sat | mi0.sat | mi3.sat;
      end
      XF_ABCD: begin
        ops[0] = mk1(in_mat[2], ONE_C);
        ops[1] = mk1(in_mat[0], ONE_C);
        ops[2] = mk2(in_mat[0], in_mat[3], in_mat[1], in_mat[2], 1'b1);
        ops[3] = mk1(ONE_C, ONE_C);
        ops[4] = mk1(in_mat[3], ONE_C);
      end
      XF_Z2S: begin
        ops[0]  = mk2(pl0.val, pl3.val, in_mat[1], in_mat[2], 1'b1);
        ops[1]  = mk2(mi0.val, pl3.val, in_mat[1], in_mat[2], 1'b1);
        ops[2]  = mk1(in_mat[1], ONE_C);
        ops[3]  = mk1(in_mat[2], ONE_C);
        ops[4]  = mk2(pl0.val, mi3.val, in_mat[1], in_mat[2], 1'b1);
        pre_sat = pl0.sat | pl3.sat | mi0.sat | mi3.sat;
      end
      default: mode_bad = 1'b1;
    endcase
  end

  // lanes 2j / 2j+1 carry real / imaginary part of numerator j
  logic [7:0] scl, dbl;
  always_comb begin
    for (int l = 0; l < 8; l++) begin
      dbl[l] = ((mode == XF_S2Z) || (mode == XF_Z2S)) && ((l >> 1) == 1 || (l >> 1) == 2);
      scl[l] = (mode == XF_S2Z) || dbl[l];
    end
  end

  mac_t      op_r [5];
  xf_flags_t fl1_r;
  always_ff @(posedge clk) begin
    if (en) for (int k = 0; k < 5; k++) op_r[k] <= ops[k];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl1_r <= '0;
    else if (en) fl1_r <= '{valid: in_flags.valid, bad: in_flags.bad | mode_bad,
                            sat: in_flags.sat | pre_sat};
  end

  // ---------------- products ----------------
  prod_t     pr_r [5][8];
  logic      sub2_r [5];
  xf_flags_t fl2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        pr_r[k][0] <= smul(op_r[k].p.re, op_r[k].q.re);
        pr_r[k][1] <= smul(op_r[k].p.im, op_r[k].q.im);
        pr_r[k][2] <= smul(op_r[k].p.re, op_r[k].q.im);
        pr_r[k][3] <= smul(op_r[k].p.im, op_r[k].q.re);
        pr_r[k][4] <= smul(op_r[k].r.re, op_r[k].s.re);
        pr_r[k][5] <= smul(op_r[k].r.im, op_r[k].s.im);
        pr_r[k][6] <= smul(op_r[k].r.re, op_r[k].s.im);
        pr_r[k][7] <= smul(op_r[k].r.im, op_r[k].s.re);
        sub2_r[k]  <= op_r[k].sub;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl2_r <= '0;
    else if (en) fl2_r <= fl1_r;
  end

  // ---------------- exact sums ----------------
  acc_t      sre_r [5], sim_r [5];
  xf_flags_t fl3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        sre_r[k] <= sub2_r[k]
          ? (acc_t'(pr_r[k][0]) - acc_t'(pr_r[k][1])) - (acc_t'(pr_r[k][4]) - acc_t'(pr_r[k][5]))
          : (acc_t'(pr_r[k][0]) - acc_t'(pr_r[k][1])) + (acc_t'(pr_r[k][4]) - acc_t'(pr_r[k][5]));
        sim_r[k] <= sub2_r[k]
          ? (acc_t'(pr_r[k][2]) + acc_t'(pr_r[k][3])) - (acc_t'(pr_r[k][6]) + acc_t'(pr_r[k][7]))
          : (acc_t'(pr_r[k][2]) + acc_t'(pr_r[k][3])) + (acc_t'(pr_r[k][6]) + acc_t'(pr_r[k][7]));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl3_r <= '0;
    else if (en) fl3_r <= fl2_r;
  end

  // ---------------- round to words ----------------
  wsat_t     rre [5], rim [5];
  logic      rnd_sat;
  always_comb begin
    rnd_sat = 1'b0;
    for (int k = 0; k < 5; k++) begin
      rre[k]  = round_word(sre_r[k]);
      rim[k]  = round_word(sim_r[k]);
      rnd_sat = rnd_sat | rre[k].sat | rim[k].sat;
    end
  end

  cplx_t     mac_r [5];
  xf_flags_t fl4_r;
  always_ff @(posedge clk) begin
    if (en) for (int k = 0; k < 5; k++) mac_r[k] <= '{re: rre[k].val, im: rim[k].val};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl4_r <= '0;
    else if (en) fl4_r <= '{valid: fl3_r.valid, bad: fl3_r.bad, sat: fl3_r.sat | rnd_sat};
  end

  // ---------------- division products, drop singular ----------------
  logic      det_zero;
  prod_t     sq_r [2];
  prod_t     nd_r [4][4];
  xf_flags_t fl5_r;
  assign det_zero = (mac_r[0].re == '0) && (mac_r[0].im == '0);
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= smul(mac_r[0].re, mac_r[0].re);
      sq_r[1] <= smul(mac_r[0].im, mac_r[0].im);
      for (int j = 0; j < 4; j++) begin
        nd_r[j][0] <= smul(mac_r[j+1].re, mac_r[0].re);
        nd_r[j][1] <= smul(mac_r[j+1].im, mac_r[0].im);
        nd_r[j][2] <= smul(mac_r[j+1].im, mac_r[0].re);
        nd_r[j][3] <= smul(mac_r[j+1].re, mac_r[0].im);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl5_r <= '0;
    else if (en) fl5_r <= '{valid: fl4_r.valid, bad: fl4_r.bad | det_zero, sat: fl4_r.sat};
  end

  logic [MAG_W-1:0] den6_r;
  num_t             num_r [8];
  xf_flags_t        fl6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      den6_r <= MAG_W'(sq_r[0]) + MAG_W'(sq_r[1]);
      for (int j = 0; j < 4; j++) begin
        num_r[2*j]   <= num_t'(nd_r[j][0]) + num_t'(nd_r[j][1]);
        num_r[2*j+1] <= num_t'(nd_r[j][2]) - num_t'(nd_r[j][3]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl6_r <= '0;
    else if (en) fl6_r <= fl5_r;
  end

  // ---------------- sign and magnitude ----------------
  logic [MAG_W-1:0] den7_r;
  logic [MAG_W-1:0] mag_r [8];
  logic [7:0]       neg7_r;
  xf_flags_t        fl7_r;
  always_ff @(posedge clk) begin
    if (en) begin
      den7_r <= den6_r;
      for (int l = 0; l < 8; l++) begin
        neg7_r[l] <= num_r[l][NUM_W-1];
        mag_r[l]  <= num_r[l][NUM_W-1] ? MAG_W'(-num_r[l]) : MAG_W'(num_r[l]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl7_r <= '0;
    else if (en) fl7_r <= fl6_r;
  end

  // ---------------- restoring division, one quotient bit per stage ----------------
  logic [SHN_W-1:0] rem_r [ITER+1][8];
  logic [QUO_W-1:0] quo_r [ITER+1][8];
  logic [MAG_W-1:0] dvs_r [ITER+1];
  logic [7:0]       neg_r [ITER+1];
  logic [7:0]       ovf_r [ITER+1];
  xf_flags_t        dfl_r [ITER+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r[0] <= den7_r;
      neg_r[0] <= neg7_r;
      for (int l = 0; l < 8; l++) begin
        rem_r[0][l] <= {mag_r[l], {FRAC_W{1'b0}}};
        quo_r[0][l] <= '0;
        // quotient of 2^QUO_W or more saturates whatever the lower bits
        ovf_r[0][l] <= CMP_W'({mag_r[l], {FRAC_W{1'b0}}}) >= (CMP_W'(den7_r) << QUO_W);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) dfl_r[0] <= '0;
    else if (en) dfl_r[0] <= fl7_r;
  end

  for (genvar k = 0; k < ITER; k++) begin : g_iter
    localparam int BIT = QUO_W - 1 - k;
    for (genvar l = 0; l < 8; l++) begin : g_lane
      logic [CMP_W-1:0] shd, rx;
      logic             ge;
      assign shd = CMP_W'(dvs_r[k]) << BIT;
      assign rx  = CMP_W'(rem_r[k][l]);
      assign ge  = rx >= shd;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1][l] <= ge ? SHN_W'(rx - shd) : rem_r[k][l];
          quo_r[k+1][l] <= quo_r[k][l] | (ge ? (QUO_W'(1) << BIT) : '0);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[k+1] <= dvs_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dfl_r[k+1] <= '0;
      else if (en) dfl_r[k+1] <= dfl_r[k];
    end
  end

  // ---------------- quotient rounding ----------------
  wsat_t qw [8];
  logic  q_sat;
  always_comb begin
    logic [MAG_W:0]   r2;
    logic [QUO_W:0]   q33;
    logic [ACC_W-1:0] qm;
    q_sat = 1'b0;
    for (int l = 0; l < 8; l++) begin
      r2    = {rem_r[ITER][l][MAG_W-1:0], 1'b0};
      q33   = {1'b0, quo_r[ITER][l]} + (QUO_W+1)'(r2 >= {1'b0, dvs_r[ITER]});
      qm    = ovf_r[ITER][l] ? '1 : ACC_W'(q33);
      qw[l] = from_mag(neg_r[ITER][l], qm);
      q_sat = q_sat | qw[l].sat;
    end
  end

  word_t     dv_r [8];
  xf_flags_t fl9_r;
  always_ff @(posedge clk) begin
    if (en) for (int l = 0; l < 8; l++) dv_r[l] <= qw[l].val;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl9_r <= '0;
    else if (en) fl9_r <= '{valid: dfl_r[ITER].valid, bad: dfl_r[ITER].bad,
                            sat: dfl_r[ITER].sat | q_sat};
  end

  // ---------------- reference scaling ----------------
  prod_t     pm_r [8];
  word_t     pv_r [8];
  xf_flags_t fl10_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 8; l++) begin
        pm_r[l] <= smul(dv_r[l], rz);
        pv_r[l] <= dv_r[l];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl10_r <= '0;
    else if (en) fl10_r <= fl9_r;
  end

  wsat_t sw [8];
  logic  s_sat;
  always_comb begin
    s_sat = 1'b0;
    for (int l = 0; l < 8; l++) begin
      sw[l] = scl[l] ? round_word(acc_t'(pm_r[l])) : '{val: pv_r[l], sat: 1'b0};
      s_sat = s_sat | sw[l].sat;
    end
  end

  word_t     sv_r [8];
  xf_flags_t fl11_r;
  always_ff @(posedge clk) begin
    if (en) for (int l = 0; l < 8; l++) sv_r[l] <= sw[l].val;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl11_r <= '0;
    else if (en) fl11_r <= '{valid: fl10_r.valid, bad: fl10_r.bad, sat: fl10_r.sat | s_sat};
  end

  // ---------------- doubling ----------------
  wsat_t dw [8];
  logic  d_sat;
  always_comb begin
    d_sat = 1'b0;
    for (int l = 0; l < 8; l++) begin
      dw[l] = dbl[l] ? add_sat(sv_r[l], sv_r[l], 1'b0) : '{val: sv_r[l], sat: 1'b0};
      d_sat = d_sat | dw[l].sat;
    end
  end

  word_t     ov_r [8];
  xf_flags_t fl12_r;
  always_ff @(posedge clk) begin
    if (en) for (int l = 0; l < 8; l++) ov_r[l] <= dw[l].val;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fl12_r <= '0;
    else if (en) fl12_r <= '{valid: fl11_r.valid, bad: fl11_r.bad, sat: fl11_r.sat | d_sat};
  end

  assign out_flags = fl12_r;
  always_comb begin
    for (int j = 0; j < 4; j++) out_mat[j] = '{re: ov_r[2*j], im: ov_r[2*j+1]};
  end

endmodule

FILE: rtl/core/two_port_param_convert_top.sv
// Top level of the two-port parameter converter: config registers, two
// conversion passes (source kind to Z, Z to target kind) and the output skid.
// Depends on tpc_pkg and tpc_xform.
`timescale 1ns / 1ps
// How to use:
//   - in_*: one word per cycle while in_tready is high, each a complex 2x2 matrix,
//     packed in in_tdata as a11_re, a11_im, a12_re, a12_im, a21_re, a21_im, a22_re,
//     a22_im (Q16.16), lowest bits first.
//   - out_*: one word per input word, same element order in out_tdata;
//     out_tuser carries status (0 ok, 1 singular, 2 saturated). A singular
//     word carries an all-zero matrix.
//   - cfg_*: register writes, index 0 source kind, 1 target kind, 2 reference
//     impedance. Write only while no word is in flight. cfg_ready is always high.
// Pipeline and throughput: two 44-stage conversion passes (each holds a 32-stage
//   bit-per-stage divider), then the output register. One word per cycle sustained
//   while the output does not stall.
// Stall: the output register has a one-word skid behind it; once the skid
//   fills, the whole pipeline holds and in_tready drops. Nothing is lost.
// Reset: rst_n (synchronous, active low) empties the pipeline and restores
//   source Z, target S and a fifty-ohm reference.
module two_port_param_convert_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // a11_re, a11_im, a12_re, a12_im, a21_re, a21_im, a22_re, a22_im
  input  logic [tpc_pkg::MAT_W-1:0] in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // b11_re, b11_im, b12_re, b12_im, b21_re, b21_im, b22_re, b22_im
  output logic [tpc_pkg::MAT_W-1:0] out_tdata,
  // status
  output logic [1:0]                out_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [tpc_pkg::WORD_W-1:0] cfg_data
);
  import tpc_pkg::*;

  typedef struct packed {
    cplx_t [3:0] mat;
    logic [1:0]  st;
  } res_t;

  // ---------------- configuration ----------------
  logic [1:0]      src_r, tgt_r;
  logic [RZ_W-1:0] rz_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= SRC_Z;
      tgt_r <= TGT_S;
      rz_r  <= RZ_RESET;
    end else if (cfg_valid) begin
      // drop writes to unknown indexes
      if (cfg_index == REG_SOURCE) src_r <= cfg_data[1:0];
      if (cfg_index == REG_TARGET) tgt_r <= cfg_data[1:0];
      if (cfg_index == REG_REFZ)   rz_r  <= cfg_data[RZ_W-1:0];
    end
  end

  xf_mode_t mode1, mode2;
  word_t    rz_w;
  assign rz_w = word_t'({1'b0, rz_r});

  always_comb begin
    unique case (src_r)
      SRC_Z:   mode1 = XF_PASS;
      SRC_Y:   mode1 = XF_INV;
      SRC_S:   mode1 = XF_S2Z;
      default: mode1 = XF_BAD;
    endcase
  end

  always_comb begin
    unique case (tgt_r)
      TGT_Z:    mode2 = XF_PASS;
      TGT_Y:    mode2 = XF_INV;
      TGT_ABCD: mode2 = XF_ABCD;
      TGT_S:    mode2 = XF_Z2S;
      default:  mode2 = XF_PASS;
    endcase
  end

  // ---------------- datapath ----------------
  logic        skid_full_r;
  logic        pipe_en;
  cplx_t [3:0] in_mat, mat1, mat2;
  xf_flags_t   fl0, fl1, fl2;

  // hold the whole pipeline while the skid word waits
  assign pipe_en   = !skid_full_r;
  assign in_tready = pipe_en;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_mat[i].re = in_tdata[2*i*WORD_W +: WORD_W];
      in_mat[i].im = in_tdata[(2*i+1)*WORD_W +: WORD_W];
    end
    fl0 = '{valid: in_tvalid, bad: 1'b0, sat: 1'b0};
  end

  tpc_xform u_to_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .mode      (mode1),
    .rz        (rz_w),
    .in_flags  (fl0),
    .in_mat    (in_mat),
    .out_flags (fl1),
    .out_mat   (mat1)
  );

  tpc_xform u_from_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .mode      (mode2),
    .rz        (rz_w),
    .in_flags  (fl1),
    .in_mat    (mat1),
    .out_flags (fl2),
    .out_mat   (mat2)
  );

  // singular wins over saturated; zero the matrix on singular
  res_t res;
  always_comb begin
    res.mat = fl2.bad ? '0 : mat2;
    res.st  = fl2.bad ? ST_SINGULAR : (fl2.sat ? ST_SAT : ST_OK);
  end

  // ---------------- output register and skid ----------------
  logic out_valid_r, out_valid_nxt, skid_full_nxt;
  logic load_out, load_skid, from_skid;
  res_t out_r, skid_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    from_skid     = 1'b0;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (skid_full_r) begin
      // advance the skid word once the output word is taken
      if (out_tready) begin
        from_skid     = 1'b1;
        out_valid_nxt = 1'b1;
        skid_full_nxt = 1'b0;
      end
    end else if (fl2.valid) begin
      if (!out_valid_r || out_tready) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid     = 1'b1;
        skid_full_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (from_skid)     out_r <= skid_r;
    else if (load_out) out_r <= res;
    if (load_skid)     skid_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.st;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      out_tdata[2*i*WORD_W +: WORD_W]     = out_r.mat[i].re;
      out_tdata[(2*i+1)*WORD_W +: WORD_W] = out_r.mat[i].im;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for two_port_param_convert_top: streams complex 2x2
// matrices through directed and random source/target pairings and checks each result word.
// Depends on tpc_pkg and the converter RTL only.
`timescale 1ns / 1ps
module tb_top;
  import tpc_pkg::*;

  // Codes the package leaves out: the fourth register index and source kind.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] SRC_UNUSED = 2'd3;

  localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_MONE = 32'hffff_0000;
  localparam logic [30:0] RZ_MAX = 31'h7fff_ffff;

  typedef logic signed [159:0] wide_t;
  typedef struct {
    longint re;
    longint im;
  } cx_t;
  typedef struct {
    logic [MAT_W-1:0] mat;
    logic [1:0]       st;
  } conv_res_t;
  typedef struct {
    logic [1:0]       src;
    logic [1:0]       tgt;
    logic [30:0]      refz;
    logic [MAT_W-1:0] mat;
    bit               known;  // expected word typed in below, not predicted
    logic [1:0]       kst;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic [MAT_W-1:0] in_tdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [MAT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;

  two_port_param_convert_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the converter's registers, updated on each accepted write.
  logic [1:0]  src_kind = SRC_Z;
  logic [1:0]  tgt_kind = TGT_S;
  logic [30:0] ref_z    = RZ_RESET;

  conv_res_t expected_q[$];
  int        err_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_cnt = 0;
  bit        conv_sat;

  // ---------------------------------------------------------------------------
  // Converter arithmetic: exact products and sums, one rounding per result,
  // saturation to the word range with a sticky flag.
  // ---------------------------------------------------------------------------
  function automatic wide_t wmul(input longint a, input longint b);
    wide_t x;
    wide_t y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic longint sat_mag(input bit neg, input wide_t m);
    wide_t lim;
    lim = neg ? (wide_t'(1) <<< 31) : (wide_t'(1) <<< 31) - 1;
    if (m > lim) begin
      conv_sat = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_q(input wide_t v);
    bit neg;
    wide_t m;
    neg = v < 0;
    m = neg ? -v : v;
    m = (m + (wide_t'(1) <<< 15)) >>> 16;
    return sat_mag(neg, m);
  endfunction

  function automatic longint div_q(input wide_t num, input wide_t den);
    bit neg;
    wide_t n;
    wide_t q;
    wide_t r;
    neg = num < 0;
    n = (neg ? -num : num) <<< 16;
    q = n / den;
    r = n - q * den;
    if (2 * r >= den) q = q + 1;
    return sat_mag(neg, q);
  endfunction

  function automatic longint clamp_w(input longint v);
    if (v > 64'sd2147483647) begin
      conv_sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      conv_sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // p*q + r*s, or p*q - r*s
  function automatic cx_t cmac(input cx_t p, input cx_t q, input cx_t r, input cx_t s,
                               input bit sub);
    wide_t re;
    wide_t im;
    wide_t re2;
    wide_t im2;
    cx_t o;
    re  = wmul(p.re, q.re) - wmul(p.im, q.im);
    im  = wmul(p.re, q.im) + wmul(p.im, q.re);
    re2 = wmul(r.re, s.re) - wmul(r.im, s.im);
    im2 = wmul(r.re, s.im) + wmul(r.im, s.re);
    o.re = round_q(sub ? re - re2 : re + re2);
    o.im = round_q(sub ? im - im2 : im + im2);
    return o;
  endfunction

  function automatic cx_t cmul(input cx_t p, input cx_t q);
    cx_t z;
    z = '{0, 0};
    return cmac(p, q, z, z, 1'b0);
  endfunction

  function automatic cx_t cdiv(input cx_t p, input cx_t d);
    wide_t den;
    cx_t o;
    den = wmul(d.re, d.re) + wmul(d.im, d.im);
    o.re = div_q(wmul(p.re, d.re) + wmul(p.im, d.im), den);
    o.im = div_q(wmul(p.im, d.re) - wmul(p.re, d.im), den);
    return o;
  endfunction

  function automatic cx_t cadd(input cx_t a, input cx_t b, input bit sub);
    cx_t o;
    o.re = clamp_w(sub ? a.re - b.re : a.re + b.re);
    o.im = clamp_w(sub ? a.im - b.im : a.im + b.im);
    return o;
  endfunction

  function automatic cx_t cneg(input cx_t a);
    cx_t o;
    o.re = clamp_w(-a.re);
    o.im = clamp_w(-a.im);
    return o;
  endfunction

  function automatic bit czero(input cx_t a);
    return a.re == 0 && a.im == 0;
  endfunction

  // Work out the converted matrix and status for one accepted input word.
  function automatic conv_res_t convert_matrix(input logic [MAT_W-1:0] m);
    cx_t a[4];
    cx_t z[4];
    cx_t b[4];
    cx_t one;
    cx_t rz;
    cx_t det;
    cx_t om0, om3, op0, op3, zp0, zp3, zm0, zm3;
    bit bad;
    conv_res_t res;
    conv_sat = 1'b0;
    bad = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i].re = longint'($signed(m[64*i +: 32]));
      a[i].im = longint'($signed(m[64*i+32 +: 32]));
    end
    one = '{65536, 0};
    rz  = '{longint'(ref_z), 0};

    case (src_kind)
      SRC_Z: z = a;
      SRC_Y: begin
        det = cmac(a[0], a[3], a[1], a[2], 1'b1);
        if (czero(det)) bad = 1'b1;
        else begin
          z[0] = cdiv(a[3], det);
          z[1] = cdiv(cneg(a[1]), det);
          z[2] = cdiv(cneg(a[2]), det);
          z[3] = cdiv(a[0], det);
        end
      end
      SRC_S: begin
        om0 = cadd(one, a[0], 1'b1);
        om3 = cadd(one, a[3], 1'b1);
        op0 = cadd(one, a[0], 1'b0);
        op3 = cadd(one, a[3], 1'b0);
        det = cmac(om0, om3, a[1], a[2], 1'b1);
        if (czero(det)) bad = 1'b1;
        else begin
          z[0] = cmul(cdiv(cmac(op0, om3, a[1], a[2], 1'b0), det), rz);
          z[1] = cmul(cdiv(a[1], det), rz);
          z[1] = cadd(z[1], z[1], 1'b0);
          z[2] = cmul(cdiv(a[2], det), rz);
          z[2] = cadd(z[2], z[2], 1'b0);
          z[3] = cmul(cdiv(cmac(om0, op3, a[1], a[2], 1'b0), det), rz);
        end
      end
      default: bad = 1'b1;
    endcase

    if (!bad) begin
      case (tgt_kind)
        TGT_Z: b = z;
        TGT_Y: begin
          det = cmac(z[0], z[3], z[1], z[2], 1'b1);
          if (czero(det)) bad = 1'b1;
          else begin
            b[0] = cdiv(z[3], det);
            b[1] = cdiv(cneg(z[1]), det);
            b[2] = cdiv(cneg(z[2]), det);
            b[3] = cdiv(z[0], det);
          end
        end
        TGT_ABCD: begin
          if (czero(z[2])) bad = 1'b1;
          else begin
            det = cmac(z[0], z[3], z[1], z[2], 1'b1);
            b[0] = cdiv(z[0], z[2]);
            b[1] = cdiv(det, z[2]);
            b[2] = cdiv(one, z[2]);
            b[3] = cdiv(z[3], z[2]);
          end
        end
        default: begin
          zp0 = cadd(z[0], rz, 1'b0);
          zp3 = cadd(z[3], rz, 1'b0);
          zm0 = cadd(z[0], rz, 1'b1);
          zm3 = cadd(z[3], rz, 1'b1);
          det = cmac(zp0, zp3, z[1], z[2], 1'b1);
          if (czero(det)) bad = 1'b1;
          else begin
            b[0] = cdiv(cmac(zm0, zp3, z[1], z[2], 1'b1), det);
            b[1] = cmul(cdiv(z[1], det), rz);
            b[1] = cadd(b[1], b[1], 1'b0);
            b[2] = cmul(cdiv(z[2], det), rz);
            b[2] = cadd(b[2], b[2], 1'b0);
            b[3] = cdiv(cmac(zp0, zm3, z[1], z[2], 1'b1), det);
          end
        end
      endcase
    end

    res.mat = '0;
    if (!bad) begin
      for (int i = 0; i < 4; i++) begin
        res.mat[64*i +: 32]    = b[i].re[31:0];
        res.mat[64*i+32 +: 32] = b[i].im[31:0];
      end
    end
    res.st = bad ? ST_SINGULAR : (conv_sat ? ST_SAT : ST_OK);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  function automatic logic [MAT_W-1:0] pack8(input logic [31:0] r11, input logic [31:0] i11,
                                             input logic [31:0] r12, input logic [31:0] i12,
                                             input logic [31:0] r21, input logic [31:0] i21,
                                             input logic [31:0] r22, input logic [31:0] i22);
    return {i22, r22, i21, r21, i12, r12, i11, r11};
  endfunction

  // Mostly modest values so the conversions stay meaningful; some extremes,
  // zeros and raw random words so every bit toggles and saturation happens.
  function automatic logic [31:0] rand_elem(input bit unit_scale);
    int span;
    span = unit_scale ? 32'h0001_0000 : 32'h0008_0000;
    case ($urandom_range(0, 11))
      0:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      1:       return '0;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endcase
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result.
  task automatic send_matrix(input logic [MAT_W-1:0] m, input bit known,
                             input logic [1:0] kst);
    conv_res_t res;
    // draw afresh before every idle step, so the idle share per cycle matches the setting
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (known) begin
      res.st  = kst;
      res.mat = (kst == ST_SINGULAR) ? '0 : m;
    end else begin
      res = convert_matrix(m);
    end
    expected_q.push_back(res);
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // One register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SOURCE: src_kind = val[1:0];
      REG_TARGET: tgt_kind = val[1:0];
      REG_REFZ:   ref_z    = val[30:0];
      default: ;  // unused index: ignored by the block
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] src, input logic [1:0] tgt,
                            input logic [30:0] refz);
    drain();
    write_reg(REG_SOURCE, {30'd0, src});
    write_reg(REG_TARGET, {30'd0, tgt});
    write_reg(REG_REFZ, {1'b0, refz});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off that fills the pipeline.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    conv_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("result word with no expectation: tdata=%h tuser=%0d", out_tdata, out_tuser);
        err_cnt++;
      end else begin
        exp_res = expected_q.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (out_tdata[32*k +: 32] !== exp_res.mat[32*k +: 32]) begin
            $error("b%0d%0d_%s: expected %h, got %h", k / 4 + 1, (k / 2) % 2 + 1,
                   (k % 2) ? "im" : "re", exp_res.mat[32*k +: 32], out_tdata[32*k +: 32]);
            err_cnt++;
          end
        end
        if (out_tuser !== exp_res.st) begin
          $error("status: expected %0d, got %0d", exp_res.st, out_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, reset-value check, directed table, unused-index write, randomized blocks, final drain.
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t rows[20];
    logic [MAT_W-1:0] m;
    bit unit;
    int wait_cnt;

    rows = '{
      // passthrough Z to Z: the result is the input word
      '{SRC_Z, TGT_Z, RZ_RESET, '0, 1'b1, ST_OK},
      '{SRC_Z, TGT_Z, RZ_RESET,
        pack8(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN), 1'b1, ST_OK},
      '{SRC_Z, TGT_Z, RZ_RESET,
        pack8(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
              32'h0000_0001, 32'hffff_ffff, 32'h0001_8000, 32'hfffe_8000), 1'b1, ST_OK},
      // zero determinants and divisors
      '{SRC_Z, TGT_Y, RZ_RESET, '0, 1'b1, ST_SINGULAR},
      '{SRC_Z, TGT_ABCD, RZ_RESET,
        pack8(Q_ONE, 0, Q_ONE, 0, 0, 0, Q_ONE, 0), 1'b1, ST_SINGULAR},
      '{SRC_Z, TGT_S, 31'd0, '0, 1'b1, ST_SINGULAR},
      '{SRC_Y, TGT_Z, RZ_RESET, '0, 1'b1, ST_SINGULAR},
      '{SRC_S, TGT_Z, RZ_RESET,
        pack8(Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0), 1'b1, ST_SINGULAR},
      // unused source kind is always singular
      '{SRC_UNUSED, TGT_Z, RZ_RESET,
        pack8(Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0), 1'b1, ST_SINGULAR},
      // predicted rows
      '{SRC_Z, TGT_S, RZ_RESET, '0, 1'b0, ST_OK},
      '{SRC_Z, TGT_S, RZ_RESET,
        pack8(32'h0032_0000, 0, 32'h000a_0000, 32'h0002_0000,
              32'h000a_0000, 32'hfffe_0000, 32'h0019_0000, 32'h0005_0000), 1'b0, ST_OK},
      '{SRC_Z, TGT_Y, RZ_RESET,
        pack8(Q_ONE, 0, 32'h0000_8000, 0, 0, 32'h0000_4000, Q_ONE, Q_ONE), 1'b0, ST_OK},
      '{SRC_Z, TGT_Y, RZ_RESET,
        pack8(Q_MAX, Q_MAX, 0, 0, 0, 0, Q_MIN, Q_MIN), 1'b0, ST_OK},
      '{SRC_Z, TGT_ABCD, RZ_RESET,
        pack8(32'h0003_0000, 0, 32'h0001_0000, 0, 32'h0002_0000, 32'h0001_0000,
              32'h0004_0000, 0), 1'b0, ST_OK},
      '{SRC_Y, TGT_Z, RZ_RESET,
        pack8(32'h0000_0800, 32'h0000_0100, 0, 0, 0, 0, 32'h0000_0400, 0), 1'b0, ST_OK},
      '{SRC_Y, TGT_ABCD, RZ_RESET,
        pack8(Q_ONE, 0, Q_MONE, 0, Q_MONE, 0, 32'h0002_0000, 0), 1'b0, ST_OK},
      '{SRC_S, TGT_Z, RZ_RESET, '0, 1'b0, ST_OK},
      '{SRC_S, TGT_Z, RZ_MAX,
        pack8(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN), 1'b0, ST_OK},
      '{SRC_S, TGT_S, RZ_MAX,
        pack8(32'h0000_4000, 0, 32'h0000_2000, 0, 32'h0000_2000, 0, 32'h0000_4000, 0),
        1'b0, ST_OK},
      '{SRC_Z, TGT_S, RZ_MAX,
        pack8(Q_ONE, 0, 0, 0, 0, 0, Q_MAX, Q_MAX), 1'b0, ST_OK}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values first: a zero matrix in Z to S at fifty ohms.
    send_matrix('0, 1'b0, ST_OK);

    foreach (rows[i]) begin
      if (rows[i].src != src_kind || rows[i].tgt != tgt_kind || rows[i].refz != ref_z)
        set_config(rows[i].src, rows[i].tgt, rows[i].refz);
      send_matrix(rows[i].mat, rows[i].known, rows[i].kst);
    end

    // A write to the unused index must leave every register alone.
    drain();
    write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    @(negedge clk);
    send_matrix(pack8(Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0), 1'b0, ST_OK);

    // Random blocks: fresh configuration, idle pattern rotating by block.
    for (int blk = 0; blk < 10; blk++) begin
      logic [30:0] refz;
      case ($urandom_range(0, 5))
        0:       refz = 31'd0;
        1:       refz = RZ_MAX;
        2:       refz = 31'($urandom);
        default: refz = 31'($urandom_range(32'h0001_0000, 32'h00c8_0000));
      endcase
      set_config(($urandom_range(0, 9) == 0) ? SRC_UNUSED : 2'($urandom_range(0, 2)),
                 2'($urandom_range(0, 3)), refz);
      case (blk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < 123; n++) begin
        // Long receiver hold-off with the sender running flat out.
        if (blk == 4 && n == 10) hold_cnt = 300;
        // Sender pauses until every expected word is back.
        if (blk == 6 && n == 60) drain();
        unit = (src_kind == SRC_S) && ($urandom_range(0, 3) != 0);
        m = pack8(rand_elem(unit), rand_elem(unit), rand_elem(unit), rand_elem(unit),
                  rand_elem(unit), rand_elem(unit), rand_elem(unit), rand_elem(unit));
        send_matrix(m, 1'b0, ST_OK);
      end
    end

    in_tvalid <= 1'b0;
    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 200000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (expected_q.size() != 0) $error("%0d result words never arrived", expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tpc_pkg.sv
rtl/core/tpc_xform.sv
rtl/core/two_port_param_convert_top.sv
tb/tb_top.sv
